[rtl/nss_pkg.sv]
// Shared types and opcodes for the nearest sample search unit.
package nss_pkg;

   localparam int TIME_PORT_WIDTH  = 48;
   localparam int INDEX_PORT_WIDTH = 10;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic [TIME_PORT_WIDTH-1:0] time_value;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_PORT_WIDTH-1:0] nearest_index;
      logic                        store_empty;
   } rsp_payload_type;

endpackage

[rtl/nss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module nss_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/nearest_sample_search_with_hint_unit.sv]
// Top level: sample store with hinted nearest-sample walk.
//
//   channel | ports                      | role
//   --------+----------------------------+-------------------------------------
//   request | req_valid/req_ready/req_data | clear, append or query transaction
//   result  | rsp_valid/rsp_ready/rsp_data | one transaction per query
//
// Clear and append complete in the idle state. A query walks from the hinted
// entry through its neighbors; an empty-store query goes straight to done.
// Each walk step is set by the one RAM read port and the shared distance unit:
// read, distance, compare. Reset empties the store and zeroes the hint; no
// clearing pass. The request side is held off while a query is in progress,
// and a query result waits in the output register until taken.
module nearest_sample_search_with_hint_unit
   import nss_pkg::*;
#(
   parameter int SAMPLE_DEPTH = 1024,
   parameter int TIME_WIDTH   = 48
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int IDX_W = $clog2(SAMPLE_DEPTH);
   localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HOME_RD,
      S_HOME_DIST,
      S_NBR_RD,
      S_NBR_DIST,
      S_CMP,
      S_DONE
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] hint_ff;
   logic [IDX_W-1:0] h_ff;
   logic [TIME_WIDTH-1:0] t_ff;
   logic [TIME_WIDTH-1:0] cur_dist_ff;
   logic [TIME_WIDTH-1:0] nbr_dist_ff;
   logic             up_ff;
   logic             empty_ff;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_data_ff;

   logic                  req_fire;
   logic [63:0]           time_ext;
   logic [TIME_WIDTH-1:0] req_time;
   logic [IDX_W-1:0]      hint_clamped;
   logic [IDX_W-1:0]      nbr_idx;
   logic                  nbr_more;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [TIME_WIDTH-1:0] ram_rd_data;
   logic [TIME_WIDTH:0]   diff_wide;
   logic                  below;
   logic [TIME_WIDTH-1:0] time_dist;
   logic [31:0]           idx_ext;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign time_ext = 64'(req_data.time_value);
   assign req_time = time_ext[TIME_WIDTH-1:0];

   // stale hint is pulled back to the last filled entry
   assign hint_clamped = (CNT_W'(hint_ff) >= count_ff) ?
                         IDX_W'(count_ff - CNT_W'(1)) : hint_ff;

   assign nbr_idx  = up_ff ? (h_ff + IDX_W'(1)) : (h_ff - IDX_W'(1));
   // can the walk go one more step past the neighbor
   assign nbr_more = up_ff ? ((CNT_W'(nbr_idx) + CNT_W'(1)) < count_ff)
                           : (nbr_idx != '0);

   // shared distance unit: sign of (stored - query) and its magnitude
   assign diff_wide = {1'b0, ram_rd_data} - {1'b0, t_ff};
   assign below     = diff_wide[TIME_WIDTH];
   assign time_dist = below ? (TIME_WIDTH'(0) - diff_wide[TIME_WIDTH-1:0])
                            : diff_wide[TIME_WIDTH-1:0];

   assign ram_wr_en   = req_fire && (req_data.opcode == OP_APPEND) &&
                        (count_ff < CNT_W'(SAMPLE_DEPTH));
   assign ram_rd_en   = (state_ff == S_HOME_RD) || (state_ff == S_NBR_RD);
   assign ram_rd_addr = (state_ff == S_HOME_RD) ? h_ff : nbr_idx;

   assign idx_ext = 32'(h_ff);

   nss_ram #(
      .WIDTH(TIME_WIDTH),
      .DEPTH(SAMPLE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data(req_time),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         up_ff        <= 1'b0;
         empty_ff     <= 1'b0;
      end else begin
         // a new result may load in the same cycle the old one is taken
         if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  unique case (req_data.opcode)
                     OP_CLEAR: begin
                        count_ff <= '0;
                     end
                     OP_APPEND: begin
                        if (ram_wr_en) begin
                           count_ff <= count_ff + CNT_W'(1);
                        end
                     end
                     OP_QUERY: begin
                        t_ff     <= req_time;
                        h_ff     <= hint_clamped;
                        empty_ff <= (count_ff == '0);
                        state_ff <= (count_ff == '0) ? S_DONE : S_HOME_RD;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_HOME_RD: begin
               state_ff <= S_HOME_DIST;
            end
            S_HOME_DIST: begin
               cur_dist_ff <= time_dist;
               up_ff       <= below;
               if (time_dist == '0) begin
                  state_ff <= S_DONE;
               end else if (below) begin
                  state_ff <= ((CNT_W'(h_ff) + CNT_W'(1)) < count_ff) ? S_NBR_RD : S_DONE;
               end else begin
                  state_ff <= (h_ff != '0) ? S_NBR_RD : S_DONE;
               end
            end
            S_NBR_RD: begin
               state_ff <= S_NBR_DIST;
            end
            S_NBR_DIST: begin
               nbr_dist_ff <= time_dist;
               state_ff    <= S_CMP;
            end
            S_CMP: begin
               // only a strictly closer neighbor moves the walk
               if (nbr_dist_ff < cur_dist_ff) begin
                  h_ff        <= nbr_idx;
                  cur_dist_ff <= nbr_dist_ff;
                  state_ff    <= nbr_more ? S_NBR_RD : S_DONE;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  if (empty_ff) begin
                     rsp_data_ff.nearest_index <= '0;
                     rsp_data_ff.store_empty   <= 1'b1;
                  end else begin
                     rsp_data_ff.nearest_index <= idx_ext[INDEX_PORT_WIDTH-1:0];
                     rsp_data_ff.store_empty   <= 1'b0;
                     hint_ff                   <= h_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the hinted nearest-sample search unit.
module testbench;
   import nss_pkg::*;

   localparam int          SAMPLE_DEPTH = 1024;
   localparam int          CYCLE_LIMIT  = 5_000_000;
   localparam int          ITEM_TARGET  = 450;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam logic [TIME_PORT_WIDTH-1:0] TIME_MAX = '1;

   typedef logic [TIME_PORT_WIDTH:0] wide_time_type;

   // Shadow copy of the store and hint; predicts one result per query.
   class nearest_sample_scoreboard;
      logic [TIME_PORT_WIDTH-1:0] shadow_times [SAMPLE_DEPTH];
      int unsigned     shadow_count;
      int unsigned     shadow_hint;
      rsp_payload_type expected_nearest [$];
      int errors, queries, empty_queries, clamped_hints;
      int up_steps, down_steps, dropped_appends, unused_ops;

      function logic [TIME_PORT_WIDTH-1:0] distance(input logic [TIME_PORT_WIDTH-1:0] a,
                                                     input logic [TIME_PORT_WIDTH-1:0] b);
         return (a > b) ? a - b : b - a;
      endfunction

      function void predict_nearest(input req_payload_type item);
         rsp_payload_type             expected;
         int unsigned                 pos;
         logic [TIME_PORT_WIDTH-1:0]  t;
         t = item.time_value;
         case (item.opcode)
            OP_CLEAR: shadow_count = 0;
            OP_APPEND: begin
               if (shadow_count < SAMPLE_DEPTH) begin
                  shadow_times[shadow_count] = t;
                  shadow_count++;
               end else begin
                  dropped_appends++;
               end
            end
            OP_QUERY: begin
               queries++;
               if (shadow_count == 0) begin
                  // hint is left alone on an empty store
                  expected.nearest_index = '0;
                  expected.store_empty   = 1'b1;
                  empty_queries++;
               end else begin
                  pos = shadow_hint;
                  if (pos >= shadow_count) begin
                     pos = shadow_count - 1;
                     clamped_hints++;
                  end
                  // walk only while strictly closer; ties stay put
                  if (shadow_times[pos] < t) begin
                     while (pos + 1 < shadow_count &&
                            distance(shadow_times[pos+1], t) < distance(shadow_times[pos], t)) begin
                        pos++;
                        up_steps++;
                     end
                  end else if (shadow_times[pos] > t) begin
                     while (pos > 0 &&
                            distance(shadow_times[pos-1], t) < distance(shadow_times[pos], t)) begin
                        pos--;
                        down_steps++;
                     end
                  end
                  shadow_hint            = pos;
                  expected.nearest_index = INDEX_PORT_WIDTH'(pos);
                  expected.store_empty   = 1'b0;
               end
               expected_nearest.push_back(expected);
            end
            default: unused_ops++;
         endcase
      endfunction

      function void check_nearest(input rsp_payload_type got);
         rsp_payload_type expected;
         if (expected_nearest.size() == 0) begin
            $display("%0t: unexpected result transaction: index %0d, empty %0b",
                     $time, got.nearest_index, got.store_empty);
            errors++;
            return;
         end
         expected = expected_nearest.pop_front();
         if (got.nearest_index !== expected.nearest_index) begin
            $display("%0t: nearest_index mismatch: expected %0d, actual %0d",
                     $time, expected.nearest_index, got.nearest_index);
            errors++;
         end
         if (got.store_empty !== expected.store_empty) begin
            $display("%0t: store_empty mismatch: expected %0b, actual %0b",
                     $time, expected.store_empty, got.store_empty);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;

   nearest_sample_scoreboard sb;
   bit req_no_gaps;
   bit rsp_no_stalls;
   int issued_items;

   nearest_sample_search_with_hint_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [TIME_PORT_WIDTH-1:0] random_time();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[TIME_PORT_WIDTH-1:0];
   endfunction

   // Entered and left at a falling edge.
   task automatic issue(input logic [1:0] op, input logic [TIME_PORT_WIDTH-1:0] t);
      req_payload_type item;
      int              gap;
      item.opcode     = op;
      item.time_value = t;
      gap = req_no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.predict_nearest(item);
      if (op != OP_UNUSED) issued_items++;
      @(negedge clock);
   endtask

   // Query time chosen around what is stored: exact hits, near misses,
   // midpoints for ties, and the odd far-away value.
   function automatic logic [TIME_PORT_WIDTH-1:0] pick_query_time();
      logic [TIME_PORT_WIDTH:0]   v;
      logic [TIME_PORT_WIDTH-1:0] s;
      int unsigned                idx, offset;
      if (sb.shadow_count == 0) return random_time();
      idx    = $urandom_range(0, sb.shadow_count - 1);
      s      = sb.shadow_times[idx];
      offset = $urandom_range(0, 3000);
      case ($urandom_range(0, 5))
         0: v = {1'b0, s};
         1: v = {1'b0, s} + wide_time_type'(offset);
         2: v = (s < offset) ? '0 : {1'b0, s} - wide_time_type'(offset);
         3: begin
            if (idx + 1 < sb.shadow_count)
               v = ({1'b0, s} + {1'b0, sb.shadow_times[idx+1]}) >> 1;
            else v = {1'b0, s};
         end
         4: v = {1'b0, random_time()};
         default: v = $urandom_range(0, 1) ? '0 : {1'b0, TIME_MAX};
      endcase
      if (v > {1'b0, TIME_MAX}) v = {1'b0, TIME_MAX};
      return v[TIME_PORT_WIDTH-1:0];
   endfunction

   // Ascending series followed by queries, with the occasional late append.
   task automatic run_series_phase(input int max_len);
      logic [TIME_PORT_WIDTH:0]   t;
      logic [TIME_PORT_WIDTH-1:0] stride;
      int                         n, nq;
      if ($urandom_range(0, 9) < 7) issue(OP_CLEAR, random_time());
      case ($urandom_range(0, 3))
         0: t = wide_time_type'($urandom_range(0, 1000));
         1: t = {1'b0, random_time()};
         2: t = {1'b0, TIME_MAX} - wide_time_type'($urandom_range(0, 5000));
         default: t = {1'b0, random_time() >> $urandom_range(1, 40)};
      endcase
      stride = ($urandom_range(0, 2) == 0) ?
               TIME_PORT_WIDTH'(2 * $urandom_range(1, 50)) : '0;
      n = $urandom_range(1, max_len);
      repeat (n) begin
         issue(OP_APPEND, t[TIME_PORT_WIDTH-1:0]);
         t = t + ((stride != '0) ? {1'b0, stride}
                                 : wide_time_type'($urandom_range(0, 2000)));
         if (t > {1'b0, TIME_MAX}) t = {1'b0, TIME_MAX};
      end
      nq = $urandom_range(1, 12);
      repeat (nq) begin
         if ($urandom_range(0, 4) == 0) begin
            issue(OP_APPEND, t[TIME_PORT_WIDTH-1:0]);
            t = t + wide_time_type'($urandom_range(0, 2000));
            if (t > {1'b0, TIME_MAX}) t = {1'b0, TIME_MAX};
         end else begin
            issue(OP_QUERY, pick_query_time());
         end
      end
   endtask

   // Any opcode, any value: unsorted stores, empty queries, unused opcode.
   task automatic run_noise_phase();
      repeat ($urandom_range(6, 16)) begin
         if ($urandom_range(0, 1)) issue(2'($urandom_range(0, 3)), random_time());
         else issue(2'($urandom_range(0, 3)), pick_query_time());
      end
   endtask

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles", CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int stall, taken;
      rsp_ready = 1'b0;
      taken     = 0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (taken % 40 == 0) rsp_no_stalls = ($urandom_range(0, 3) == 0);
         stall = rsp_no_stalls ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_nearest(rsp_data);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      sb           = new;
      issued_items = 0;
      req_no_gaps  = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      issue(OP_QUERY, 48'd777);                // empty store
      issue(OP_UNUSED, random_time());
      issue(OP_APPEND, '0);
      issue(OP_APPEND, 48'd100);
      issue(OP_APPEND, 48'd200);
      issue(OP_APPEND, 48'd300);
      issue(OP_APPEND, TIME_MAX);
      issue(OP_QUERY, 48'd300);                // exact match after upward walk
      issue(OP_QUERY, 48'd150);                // downward tie keeps higher index
      issue(OP_QUERY, 48'd250);                // upward tie keeps lower index
      issue(OP_QUERY, TIME_MAX);
      issue(OP_QUERY, '0);
      issue(OP_QUERY, TIME_MAX);
      issue(OP_CLEAR, TIME_MAX);
      issue(OP_APPEND, 48'd500);
      issue(OP_APPEND, 48'd600);
      issue(OP_QUERY, 48'd10000);              // hint beyond count gets clamped
      issue(OP_APPEND, 48'd50);
      issue(OP_QUERY, 48'd40);                 // unsorted: walk stops early
      issue(OP_CLEAR, '0);
      issue(OP_QUERY, 48'd5);

      // random
      while (issued_items < ITEM_TARGET) begin
         req_no_gaps = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            7, 8: run_noise_phase();
            9: begin
               issue(OP_CLEAR, random_time());
               issue(OP_QUERY, random_time());
            end
            default: run_series_phase(30);
         endcase
      end
      req_no_gaps = ($urandom_range(0, 1) == 0);
      run_series_phase(10);

      req_valid <= 1'b0;
      while (sb.expected_nearest.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d queries (%0d on an empty store, %0d with a clamped hint),",
               sb.queries, sb.empty_queries, sb.clamped_hints);
      $display("%0d up and %0d down walk steps, %0d dropped appends, %0d unused opcodes.",
               sb.up_steps, sb.down_steps, sb.dropped_appends, sb.unused_ops);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
